FILE: rtl/core/epmix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epmix_pkg;

	// Word width of the pool and of the datapath registers
	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = WordW / 2;

	// Mixing and finaliser constants
	localparam logic [WordW-1:0] MixK1   = 64'h87c37b91114253d5;
	localparam logic [WordW-1:0] MixK2   = 64'h4cf5ad432745937f;
	localparam logic [WordW-1:0] FinK1   = 64'hff51afd7ed558ccd;
	localparam logic [WordW-1:0] FinK2   = 64'hc4ceb9fe1a85ec53;
	localparam logic [WordW-1:0] PoolAdd = 64'h0000000052dce729;

	// Input item operation codes
	localparam logic OpAdd = 1'b0;
	localparam logic OpGet = 1'b1;

	// Index of the last multiply pass per 64-bit product on the 32x32 MAC
	localparam logic [1:0] MulLastStep = 2'd2;

	// Datapath operations
	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_SNAP,
		DP_MUL,
		DP_ROT,
		DP_XS,
		DP_MIX,
		DP_OUT
	} dp_op_t;

	// Multiplier constant select
	typedef enum logic [1:0] {
		KC_MIX1,
		KC_MIX2,
		KC_FIN1,
		KC_FIN2
	} kc_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_M1,
		ST_ADD_ROT,
		ST_ADD_M2,
		ST_ADD_MIX,
		ST_GET_M1,
		ST_GET_XS,
		ST_GET_M2,
		ST_GET_OUT
	} state_t;

	// Controller to datapath command
	typedef struct packed {
		dp_op_t     op;
		kc_sel_t    ksel;
		logic [1:0] step;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_busy;
		logic out_valid;
	} dp_status_t;

	function automatic logic [WordW-1:0] k_const(input kc_sel_t sel);
		logic [WordW-1:0] k;
		begin
			case (sel)
				KC_MIX1: k = MixK1;
				KC_MIX2: k = MixK2;
				KC_FIN1: k = FinK1;
				KC_FIN2: k = FinK2;
				default: k = MixK1;
			endcase
			return k;
		end
	endfunction

	function automatic logic [WordW-1:0] rotl31(input logic [WordW-1:0] x);
		return {x[32:0], x[63:33]};
	endfunction

	// Pool mixing: rotate left 27, then times 5 plus the additive constant
	function automatic logic [WordW-1:0] stir(input logic [WordW-1:0] x);
		logic [WordW-1:0] r;
		begin
			r = {x[36:0], x[63:37]};
			return r + {r[61:0], 2'b00} + PoolAdd;
		end
	endfunction

	function automatic logic [WordW-1:0] xs33(input logic [WordW-1:0] x);
		return x ^ {33'd0, x[63:33]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/entropy_pool_hash_mixer.sv
// Entropy pool hash mixer. Keeps a 64-bit pool, cleared by reset. An add item
// (op 0) scrambles data_word with two constant multiplies and a rotate, folds it
// into the pool and stirs the pool; it gives no result. A get item (op 1) takes
// a copy of the pool, stirs the pool and returns the copy through the fmix64
// finaliser as one random_value item. One item is worked on at a time, paced
// by the single 32x32 multiply-accumulate unit, which needs three passes per
// 64-bit product and two products per item. A finished result waits in an
// output register, so the next item is taken while it waits; a get only
// stalls at its end if the previous result has still not been taken.
`timescale 1ns / 1ps
`default_nettype none

module entropy_pool_hash_mixer (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             op,
	input  wire [epmix_pkg::WordW-1:0]      data_word,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [epmix_pkg::WordW-1:0]     random_value
);

	epmix_pkg::dp_cmd_t    cmd;
	epmix_pkg::dp_status_t status;

	epmix_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.status   (status),
		.cmd      (cmd)
	);

	epmix_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_word    (data_word),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.random_value (random_value),
		.status       (status)
	);

endmodule

`default_nettype wire

FILE: rtl/core/epmix_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module epmix_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  op,
	input  epmix_pkg::dp_status_t status,
	output epmix_pkg::dp_cmd_t    cmd
);

	epmix_pkg::state_t state_q, state_d;
	logic [1:0]         step_q, step_d;
	logic               mul_done;

	assign mul_done = (step_q == epmix_pkg::MulLastStep);

	// State and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epmix_pkg::ST_IDLE;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_ready = 1'b0;
		cmd.op   = epmix_pkg::DP_NOP;
		cmd.ksel = epmix_pkg::KC_MIX1;
		cmd.step = step_q;
		case (state_q)
			epmix_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				step_d   = 2'd0;
				if (in_valid) begin
					if (op == epmix_pkg::OpAdd) begin
						cmd.op  = epmix_pkg::DP_LOAD;
						state_d = epmix_pkg::ST_ADD_M1;
					end else begin
						cmd.op  = epmix_pkg::DP_SNAP;
						state_d = epmix_pkg::ST_GET_M1;
					end
				end
			end
			epmix_pkg::ST_ADD_M1: begin
				cmd.op   = epmix_pkg::DP_MUL;
				cmd.ksel = epmix_pkg::KC_MIX1;
				step_d   = mul_done ? 2'd0 : step_q + 2'd1;
				if (mul_done) state_d = epmix_pkg::ST_ADD_ROT;
			end
			epmix_pkg::ST_ADD_ROT: begin
				cmd.op  = epmix_pkg::DP_ROT;
				state_d = epmix_pkg::ST_ADD_M2;
			end
			epmix_pkg::ST_ADD_M2: begin
				cmd.op   = epmix_pkg::DP_MUL;
				cmd.ksel = epmix_pkg::KC_MIX2;
				step_d   = mul_done ? 2'd0 : step_q + 2'd1;
				if (mul_done) state_d = epmix_pkg::ST_ADD_MIX;
			end
			epmix_pkg::ST_ADD_MIX: begin
				cmd.op  = epmix_pkg::DP_MIX;
				state_d = epmix_pkg::ST_IDLE;
			end
			epmix_pkg::ST_GET_M1: begin
				cmd.op   = epmix_pkg::DP_MUL;
				cmd.ksel = epmix_pkg::KC_FIN1;
				step_d   = mul_done ? 2'd0 : step_q + 2'd1;
				if (mul_done) state_d = epmix_pkg::ST_GET_XS;
			end
			epmix_pkg::ST_GET_XS: begin
				cmd.op  = epmix_pkg::DP_XS;
				state_d = epmix_pkg::ST_GET_M2;
			end
			epmix_pkg::ST_GET_M2: begin
				cmd.op   = epmix_pkg::DP_MUL;
				cmd.ksel = epmix_pkg::KC_FIN2;
				step_d   = mul_done ? 2'd0 : step_q + 2'd1;
				if (mul_done) state_d = epmix_pkg::ST_GET_OUT;
			end
			epmix_pkg::ST_GET_OUT: begin
				// hold until the previous result item has gone
				if (!status.out_busy) begin
					cmd.op  = epmix_pkg::DP_OUT;
					state_d = epmix_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = epmix_pkg::ST_IDLE;
				step_d  = 2'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/epmix_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module epmix_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  epmix_pkg::dp_cmd_t                     cmd,
	input  wire [epmix_pkg::WordW-1:0]             data_word,
	input  wire                                    out_ready,
	output logic                                   out_valid,
	output logic [epmix_pkg::WordW-1:0]            random_value,
	output epmix_pkg::dp_status_t                  status
);

	logic [epmix_pkg::WordW-1:0] pool_q;
	logic [epmix_pkg::WordW-1:0] w_q;
	logic [epmix_pkg::WordW-1:0] acc_q;
	logic [epmix_pkg::WordW-1:0] result_q;
	logic                        out_valid_q;

	logic [epmix_pkg::WordW-1:0] kval;
	logic [epmix_pkg::HalfW-1:0] mul_a, mul_b;
	logic [epmix_pkg::WordW-1:0] prod;

	// Shared 32x32 MAC: lo*lo, then lo*hi and hi*lo into the upper half
	assign kval  = epmix_pkg::k_const(cmd.ksel);
	assign mul_a = (cmd.step == epmix_pkg::MulLastStep) ?
		w_q[epmix_pkg::WordW-1:epmix_pkg::HalfW] : w_q[epmix_pkg::HalfW-1:0];
	assign mul_b = (cmd.step == 2'd1) ?
		kval[epmix_pkg::WordW-1:epmix_pkg::HalfW] : kval[epmix_pkg::HalfW-1:0];
	assign prod  = {{epmix_pkg::HalfW{1'b0}}, mul_a} * {{epmix_pkg::HalfW{1'b0}}, mul_b};

	// Pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
		end else if (cmd.op == epmix_pkg::DP_SNAP) begin
			pool_q <= epmix_pkg::stir(pool_q);
		end else if (cmd.op == epmix_pkg::DP_MIX) begin
			pool_q <= epmix_pkg::stir(pool_q ^ acc_q);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			epmix_pkg::DP_LOAD: w_q <= data_word;
			epmix_pkg::DP_SNAP: w_q <= epmix_pkg::xs33(pool_q);
			epmix_pkg::DP_ROT:  w_q <= epmix_pkg::rotl31(acc_q);
			epmix_pkg::DP_XS:   w_q <= epmix_pkg::xs33(acc_q);
			epmix_pkg::DP_MUL: begin
				if (cmd.step == 2'd0) acc_q <= prod;
				else acc_q <= acc_q + {prod[epmix_pkg::HalfW-1:0], {epmix_pkg::HalfW{1'b0}}};
			end
			epmix_pkg::DP_OUT:  result_q <= epmix_pkg::xs33(acc_q);
			default: ;
		endcase
	end

	// Result item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == epmix_pkg::DP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign random_value     = result_q;
	assign status.out_valid = out_valid_q;
	assign status.out_busy  = out_valid_q & ~out_ready;

endmodule

`default_nettype wire

FILE: rtl/core/epmix_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module epmix_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire                         op,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [epmix_pkg::WordW-1:0]  random_value
);

	// A waiting result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value))
		else $error("result item changed while stalled");

	// One item at a time: busy right after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

	// A result never appears the cycle after an item is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result item appeared too early");

	// An add item accepted while no result waits shows no result at a check in its first multiply
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == epmix_pkg::OpAdd) && !out_valid
		|-> ##2 !out_valid)
		else $error("add item produced a result");

endmodule

bind entropy_pool_hash_mixer epmix_checker u_epmix_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.op           (op),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.random_value (random_value)
);

`default_nettype wire
